/* rtl/ifl_pkg.sv */
`default_nettype none

package ifl_pkg;

    localparam int IDX_W    = 10;
    localparam int CAP_W    = 11;
    localparam int STATUS_W = 2;

    // depth of the link store; index fields are IDX_W bits wide, so this stays fixed
    localparam int MAX_ENTRIES = 1024;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] node_index;
    } req_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]    alloc_index;
        logic [STATUS_W-1:0] status;
    } rsp_word_t;

    // one entry of the next-link store
    typedef struct packed {
        logic             end_mark;
        logic [IDX_W-1:0] idx;
    } link_t;

endpackage

`default_nettype wire

/* rtl/index_free_list.sv */
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_word  (cmd, node_index)
// rsp       out        rsp_valid / rsp_stall  rsp_word  (alloc_index, status)
// cfg       in         cfg_we                 cfg_data  (capacity)
//
// A push is done in ST_IDLE; a pop waits in ST_POP_WAIT, where the head's link
// comes out of the registered link memory read; the next word waits for it.
// After reset and after every capacity write the link memory is rebuilt by a
// pass over all MAX_ENTRIES entries, one a cycle; req_stall is high throughout.
// The response sits in an output register, so a new word is taken while the
// previous response is being taken; req_stall is high while rsp is stalled
// with a response still held.

module index_free_list
    import ifl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_word_t        req_word,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_word_t             rsp_word,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int AW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W     = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
    localparam int CAP_LIMIT = (MAX_ENTRIES < 2047) ? MAX_ENTRIES : 2047;

    localparam logic [1:0] ST_CLEAR    = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_POP_WAIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [IDX_W-1:0] head_index_reg, head_index_next;
    logic             head_empty_reg, head_empty_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_word_t        rsp_word_reg, rsp_word_next;

    link_t            link_mem [MAX_ENTRIES];
    link_t            rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    link_t            mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic [CAP_W-1:0] eff_cap;
    logic [CMP_W-1:0] clr_succ;
    link_t            clr_link;
    logic             req_accept;
    logic             clr_last;

    assign eff_cap = (cap_reg > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : cap_reg;

    // rebuild value of the entry under the clear counter
    assign clr_succ = CMP_W'(clr_cnt_reg) + CMP_W'(1);
    always_comb
    begin
        if (clr_succ < CMP_W'(eff_cap))
        begin
            clr_link.end_mark = 1'b0;
            clr_link.idx      = clr_succ[IDX_W-1:0];
        end
        else
        begin
            clr_link.end_mark = 1'b1;
            clr_link.idx      = '0;
        end
    end

    assign clr_last   = (clr_cnt_reg == AW'(MAX_ENTRIES - 1));
    assign req_stall  = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_word   = rsp_word_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cap_next        = cap_reg;
        head_index_next = head_index_reg;
        head_empty_next = head_empty_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_word_next   = rsp_word_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_wdata       = clr_link;
        mem_re          = 1'b0;
        mem_raddr       = AW'(head_index_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_last)
                begin
                    state_next      = ST_IDLE;
                    head_index_next = '0;
                    head_empty_next = (eff_cap == '0);
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_word_next.alloc_index = '0;
                    rsp_word_next.status      = STATUS_OK;
                    if (req_word.cmd == CMD_PUSH)
                    begin
                        if (CMP_W'(req_word.node_index) >= CMP_W'(eff_cap))
                        begin
                            rsp_word_next.status = STATUS_BAD_INDEX;
                        end
                        else
                        begin
                            mem_we             = 1'b1;
                            mem_waddr          = AW'(req_word.node_index);
                            mem_wdata.end_mark = head_empty_reg;
                            mem_wdata.idx      = head_index_reg;
                            head_index_next    = req_word.node_index;
                            head_empty_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        if (head_empty_reg ||
                            CMP_W'(head_index_reg) >= CMP_W'(MAX_ENTRIES))
                        begin
                            rsp_word_next.status = STATUS_EMPTY;
                        end
                        else
                        begin
                            rsp_word_next.alloc_index = head_index_reg;
                            mem_re                    = 1'b1;
                            state_next                = ST_POP_WAIT;
                        end
                    end
                end
            end
            ST_POP_WAIT:
            begin
                // link of the popped entry becomes the new head
                state_next = ST_IDLE;
                if (rd_data_reg.end_mark)
                begin
                    head_index_next = '0;
                    head_empty_next = 1'b1;
                end
                else
                begin
                    head_index_next = rd_data_reg.idx;
                    head_empty_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_we)
        begin
            cap_next     = cfg_data;
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            cap_reg        <= CAP_RESET;
            head_index_reg <= '0;
            head_empty_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cap_reg        <= cap_next;
            head_index_reg <= head_index_next;
            head_empty_reg <= head_empty_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        head_empty_reg |-> head_index_reg == '0)
        else $error("head index not parked at zero while list is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req_word.cmd == CMD_POP && !head_empty_reg && !cfg_we)
        |=> state_reg == ST_POP_WAIT && rsp_valid_reg)
        else $error("pop did not wait for the link read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req_word.cmd == CMD_PUSH && !cfg_we &&
         CMP_W'(req_word.node_index) < CMP_W'(eff_cap))
        |=> head_index_reg == $past(req_word.node_index) && !head_empty_reg)
        else $error("push did not become the new head");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !clr_last && !cfg_we)
        |=> state_reg == ST_CLEAR && clr_cnt_reg == $past(clr_cnt_reg) + AW'(1))
        else $error("rebuild pass skipped an entry");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ifl_pkg::*;

    localparam int ENTRIES     = MAX_ENTRIES;
    localparam int STALL_LIMIT = 4 * ENTRIES + 64;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    req_word_t        req_word;
    logic             rsp_valid;
    logic             rsp_stall;
    rsp_word_t        rsp_word;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;

    index_free_list uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    // free list as the block should hold it
    logic [CAP_W-1:0] cap_setting;
    logic [IDX_W-1:0] top_index;
    logic             list_empty;
    link_t            link_mem [ENTRIES];

    rsp_word_t        expect_q [$];
    logic [IDX_W-1:0] held_q [$];

    bit steady;
    int rsp_hold;
    int idle_cycles;
    int sent_count;
    int checked_count;
    int cap_writes;
    int fail_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int usable_entries();
        return (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
    endfunction

    function automatic void rebuild_list(input logic [CAP_W-1:0] cap);
        int n;
        cap_setting = cap;
        n = usable_entries();
        for (int i = 0; i < ENTRIES; i++)
        begin
            link_mem[i].end_mark = 1'b1;
            link_mem[i].idx      = '0;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            link_mem[i].end_mark = 1'b0;
            link_mem[i].idx      = IDX_W'(i + 1);
        end
        top_index  = '0;
        list_empty = (n == 0);
        held_q.delete();
    endfunction

    function automatic rsp_word_t predict_word(input req_word_t w);
        rsp_word_t r;
        r.alloc_index = '0;
        r.status      = STATUS_OK;
        if (w.cmd == CMD_PUSH)
        begin
            if (int'(w.node_index) >= usable_entries())
                r.status = STATUS_BAD_INDEX;
            else
            begin
                link_mem[w.node_index].end_mark = list_empty;
                link_mem[w.node_index].idx      = top_index;
                top_index  = w.node_index;
                list_empty = 1'b0;
            end
        end
        else if (list_empty)
            r.status = STATUS_EMPTY;
        else
        begin
            r.alloc_index = top_index;
            if (link_mem[top_index].end_mark)
            begin
                top_index  = '0;
                list_empty = 1'b1;
            end
            else
                top_index = link_mem[top_index].idx;
        end
        return r;
    endfunction

    function automatic req_word_t make_word(input logic cmd, input int idx);
        req_word_t w;
        w.cmd        = cmd;
        w.node_index = IDX_W'(idx);
        return w;
    endfunction

    // mostly pops and frees of handed-out indices, some stray and boundary frees
    function automatic req_word_t draw_request();
        req_word_t w;
        int pick;
        int slot;
        int bound_idx;
        pick         = $urandom_range(0, 99);
        w.cmd        = CMD_POP;
        w.node_index = IDX_W'($urandom);
        if (pick < 45 || (pick < 85 && held_q.size() == 0))
            return w;
        w.cmd = CMD_PUSH;
        if (pick < 85)
        begin
            slot         = $urandom_range(0, held_q.size() - 1);
            w.node_index = held_q[slot];
            held_q.delete(slot);
        end
        else if (pick >= 92)
        begin
            bound_idx = usable_entries() + int'($urandom_range(0, 2)) - 1;
            if (bound_idx >= 0 && bound_idx < ENTRIES)
                w.node_index = IDX_W'(bound_idx);
        end
        return w;
    endfunction

    task automatic send_word(input req_word_t w);
        int gap;
        rsp_word_t r;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (req_stall);
        r = predict_word(w);
        if (w.cmd == CMD_POP && r.status == STATUS_OK)
            held_q.push_back(r.alloc_index);
        expect_q.push_back(r);
        sent_count++;
    endtask

    task automatic wait_results_done();
        req_valid <= 1'b0;
        while (expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_results_done();
        // let a pending link read settle before the rebuild
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        rebuild_list(value);
        cap_writes++;
    endtask

    // response side: check each word, then hold off for a random while
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expect_q.size() == 0)
            begin
                $error("response word with nothing expected: alloc_index %0d status %0d",
                       rsp_word.alloc_index, rsp_word.status);
                fail_count++;
            end
            else
            begin
                if (rsp_word.alloc_index !== expect_q[0].alloc_index)
                begin
                    $error("alloc_index: expected %0d, actual %0d",
                           expect_q[0].alloc_index, rsp_word.alloc_index);
                    fail_count++;
                end
                if (rsp_word.status !== expect_q[0].status)
                begin
                    $error("status: expected %0d, actual %0d",
                           expect_q[0].status, rsp_word.status);
                    fail_count++;
                end
                void'(expect_q.pop_front());
                checked_count++;
            end
            rsp_hold = steady ? 0 : $urandom_range(0, 7);
        end
        rsp_stall <= (rsp_hold != 0);
        if (rsp_hold != 0)
            rsp_hold--;
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_reset_list();
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_POP, 1023));
        send_word(make_word(CMD_PUSH, 1023));
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_PUSH, 0));
        send_word(make_word(CMD_POP, 0));
    endtask

    task automatic test_empty_capacity();
        write_capacity(11'd0);
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_PUSH, 0));
    endtask

    task automatic test_single_entry();
        write_capacity(11'd1);
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_PUSH, 1));
        send_word(make_word(CMD_PUSH, 0));
        send_word(make_word(CMD_POP, 0));
    endtask

    task automatic test_capacity_clamp();
        write_capacity(11'h7FF);
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_PUSH, 1023));
        send_word(make_word(CMD_POP, 0));
    endtask

    task automatic test_double_free();
        write_capacity(11'd2);
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_PUSH, 0));
        send_word(make_word(CMD_PUSH, 0));
        send_word(make_word(CMD_POP, 0));
        send_word(make_word(CMD_POP, 0));
    endtask

    task automatic run_random(input logic [CAP_W-1:0] cap, input int count);
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            steady = ((i / 16) % 4) == 1;
            // sender holds back until everything in flight has come out
            if (i == count / 2)
                wait_results_done();
            send_word(draw_request());
        end
        steady = 1'b0;
    endtask

    task automatic test_random_mix();
        run_random(11'd8, 90);
        run_random(11'd3, 60);
        run_random(CAP_RESET, 100);
        run_random(11'h7FF, 50);
        run_random(11'd1, 40);
        run_random(11'd0, 20);
        run_random(11'd37, 90);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        rsp_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        steady    = 1'b0;
        rsp_hold  = 0;
        idle_cycles   = 0;
        sent_count    = 0;
        checked_count = 0;
        cap_writes    = 0;
        fail_count    = 0;
        rebuild_list(CAP_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_list();
        test_empty_capacity();
        test_single_entry();
        test_capacity_clamp();
        test_double_free();
        test_random_mix();

        wait_results_done();
        repeat (16) @(posedge clk);
        $display("%0d requests sent, %0d responses checked, %0d capacity writes",
                 sent_count, checked_count, cap_writes);
        $display("capacities 0, 1, 2, 3, 8, 37, 1024, 2047; empty pops, bad and double frees");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
